>>> hdl/dtsd_pkg.sv
// Shared types, constants and the double rounding function of the scientific-text block.
package dtsd_pkg;

  localparam int FRACTION_DIGITS = 4;
  localparam int DIG_W = $clog2(FRACTION_DIGITS + 1);
  localparam int MANT_W = 53;
  localparam int EXP_W = 13;
  localparam int DEXP_W = 10;
  localparam int DIV_W = 64;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'd8;
  localparam logic [15:0] DIV_RECIP = 16'hCCCD;
  localparam int DIV_RECIP_SHIFT = 19;

  localparam logic [MANT_W-1:0] TENTH_MANT = 53'h1999999999999A;
  localparam logic signed [EXP_W-1:0] TENTH_EXP = -13'sd56;
  localparam logic signed [EXP_W-1:0] ONE_EXP = -13'sd52;
  localparam logic signed [EXP_W-1:0] SUBNORM_EXP = -13'sd1074;
  localparam logic signed [EXP_W-1:0] EXP_BIAS = 13'sd1075;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NONE = 8'h00;

  typedef enum logic [1:0] {
    K_NUM,
    K_ZERO,
    K_INVALID
  } dtsd_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_SCALE,
    S_DIV,
    S_DMUL,
    S_SPLIT,
    S_EMIT,
    S_WAIT
  } dtsd_state_e;

  typedef enum logic [3:0] {
    T_SIGN,
    T_INT,
    T_DOT,
    T_FRAC,
    T_E,
    T_ESIGN,
    T_EH,
    T_ET,
    T_EO,
    T_ZERO,
    T_INVALID
  } dtsd_tok_e;

  typedef struct packed {
    logic [MANT_W-1:0] m;
    logic signed [EXP_W-1:0] e;
  } dtsd_fp_t;

  typedef struct packed {
    logic done;
    logic [55:0] q;
    logic sticky;
  } dtsd_div_rsp_t;

  typedef struct packed {
    dtsd_kind_e kind;
    logic neg;
    logic [FRACTION_DIGITS:0][3:0] digits;
    logic exp_neg;
    logic [3:0] eh;
    logic [3:0] et;
    logic [3:0] eo;
  } dtsd_job_t;

  function automatic dtsd_fp_t dtsd_round57(logic [56:0] r, logic st,
                                            logic signed [EXP_W-1:0] er);
    logic [MANT_W-1:0] mt;
    logic g;
    logic s;
    logic signed [EXP_W-1:0] ex;
    logic [MANT_W:0] sum;
    dtsd_fp_t res;
    if (r[56]) begin
      mt = r[56:4];
      g = r[3];
      s = (|r[2:0]) | st;
      ex = er + 13'sd4;
    end else begin
      mt = r[55:3];
      g = r[2];
      s = (|r[1:0]) | st;
      ex = er + 13'sd3;
    end
    sum = {1'b0, mt} + (MANT_W + 1)'(g & (s | mt[0]));
    if (sum[MANT_W]) begin
      res.m = sum[MANT_W:1];
      res.e = ex + 13'sd1;
    end else begin
      res.m = sum[MANT_W-1:0];
      res.e = ex;
    end
    return res;
  endfunction

endpackage

>>> hdl/dtsd_div10.sv
// Byte-per-cycle divider of a significand by ten using a reciprocal multiply.
module dtsd_div10
  import dtsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MANT_W-1:0]   m_i,
  output dtsd_div_rsp_t       rsp_o
);

  logic [DIV_W-1:0] sh_q, sh_d;
  logic [3:0] r_q, r_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [11:0] part;
  logic [27:0] prod;
  logic [7:0] qd;
  logic [11:0] back;

  always_comb begin
    sh_d = sh_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    part = {r_q, sh_q[DIV_W-1 -: 8]};
    prod = {16'd0, part} * {12'd0, DIV_RECIP};
    qd = prod[DIV_RECIP_SHIFT +: 8];
    back = part - ({1'b0, qd, 3'b000} + {3'b000, qd, 1'b0});
    if (start_i) begin
      sh_d = {5'd0, m_i, 6'd0};
      r_d = 4'd0;
      cnt_d = DIV_STEPS;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d = back[3:0];
      sh_d = {sh_q[DIV_W-9:0], qd};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q <= r_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q = sh_q[55:0];
  assign rsp_o.sticky = (r_q != 4'd0);

endmodule

>>> hdl/dtsd_emit.sv
// Character sequencer and output register of the scientific-text block.
module dtsd_emit
  import dtsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dtsd_job_t  job_i,
  output logic       busy_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] character_o,
  output logic       is_last_o,
  output logic       invalid_o
);

  dtsd_job_t job_q, job_d;
  dtsd_tok_e tok_q, tok_d;
  logic [DIG_W-1:0] fidx_q, fidx_d;
  logic busy_q, busy_d;
  logic valid_q, valid_d;
  logic [7:0] char_q, char_d;
  logic last_q, last_d;
  logic inv_q, inv_d;
  logic [7:0] ch;
  logic last;
  logic inv;
  dtsd_tok_e nxt;
  dtsd_tok_e exp_first;
  logic load;

  always_comb begin
    if (job_q.eh != 4'd0) exp_first = T_EH;
    else if (job_q.et != 4'd0) exp_first = T_ET;
    else exp_first = T_EO;
    ch = CH_NONE;
    last = 1'b0;
    inv = 1'b0;
    nxt = tok_q;
    unique case (tok_q)
      T_SIGN: begin
        ch = CH_MINUS;
        nxt = T_INT;
      end
      T_INT: begin
        ch = CH_ZERO + {4'd0, job_q.digits[0]};
        nxt = T_DOT;
      end
      T_DOT: begin
        ch = CH_DOT;
        nxt = T_FRAC;
      end
      T_FRAC: begin
        ch = CH_ZERO + {4'd0, job_q.digits[fidx_q]};
        if (fidx_q == DIG_W'(FRACTION_DIGITS)) nxt = T_E;
      end
      T_E: begin
        ch = CH_E;
        nxt = job_q.exp_neg ? T_ESIGN : exp_first;
      end
      T_ESIGN: begin
        ch = CH_MINUS;
        nxt = exp_first;
      end
      T_EH: begin
        ch = CH_ZERO + {4'd0, job_q.eh};
        nxt = T_ET;
      end
      T_ET: begin
        ch = CH_ZERO + {4'd0, job_q.et};
        nxt = T_EO;
      end
      T_EO: begin
        ch = CH_ZERO + {4'd0, job_q.eo};
        last = 1'b1;
      end
      T_ZERO: begin
        ch = CH_ZERO;
        last = 1'b1;
      end
      T_INVALID: begin
        ch = CH_NONE;
        last = 1'b1;
        inv = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    job_d = job_q;
    tok_d = tok_q;
    fidx_d = fidx_q;
    busy_d = busy_q;
    valid_d = valid_q;
    char_d = char_q;
    last_d = last_q;
    inv_d = inv_q;
    load = busy_q && (!valid_q || !out_stall_i);
    if (valid_q && !out_stall_i) valid_d = 1'b0;
    if (start_i) begin
      job_d = job_i;
      busy_d = 1'b1;
      fidx_d = DIG_W'(1);
      unique case (job_i.kind)
        K_INVALID: tok_d = T_INVALID;
        K_ZERO: tok_d = T_ZERO;
        default: tok_d = job_i.neg ? T_SIGN : T_INT;
      endcase
    end else if (load) begin
      valid_d = 1'b1;
      char_d = ch;
      last_d = last;
      inv_d = inv;
      tok_d = nxt;
      if (tok_q == T_FRAC) fidx_d = fidx_q + 1'b1;
      if (last) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      valid_q <= 1'b0;
      tok_q <= T_INT;
      fidx_q <= '0;
    end else begin
      busy_q <= busy_d;
      valid_q <= valid_d;
      tok_q <= tok_d;
      fidx_q <= fidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    char_q <= char_d;
    last_q <= last_d;
    inv_q <= inv_d;
  end

  assign busy_o = busy_q;
  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign is_last_o = last_q;
  assign invalid_o = inv_q;

endmodule

>>> hdl/double_to_scientific_decimal_text.sv
// Top level: converts a raw double into scientific-notation ASCII text, one beat per character.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i, in_stall_o   value_bits_i (64 bits)
//   out      output     out_valid_o, out_stall_i character_o, is_last_o, invalid_o
//
// Zero, infinity and NaN go straight to the emitter. A finite value is scaled by divides by
// ten in the shared divider, which resolves eight quotient bits per cycle, and by multiplies
// by ten; the fraction of each digit is renormalized with the one-bit shifter, and the text
// leaves at one output beat per character while the output is not stalled.
// Reset clears the sequencer and the output register; no memory is cleared.
// The input is stalled from acceptance until the last character is loaded into the output
// register; output stalls hold the emitter and, through it, the input.
module double_to_scientific_decimal_text
  import dtsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  character_o,
  output logic        is_last_o,
  output logic        invalid_o
);

  dtsd_state_e state_q, state_d;
  logic [MANT_W-1:0] m_q, m_d;
  logic signed [EXP_W-1:0] e_q, e_d;
  logic signed [DEXP_W-1:0] e10_q, e10_d;
  logic neg_q, neg_d;
  logic mulph_q, mulph_d;
  logic z_q, z_d;
  logic indig_q, indig_d;
  dtsd_kind_e kind_q, kind_d;
  logic [FRACTION_DIGITS:0][3:0] dig_q, dig_d;
  logic [DIG_W-1:0] dcnt_q, dcnt_d;

  logic div_start;
  dtsd_div_rsp_t div_rsp;
  logic emit_start;
  logic emit_busy;
  dtsd_job_t job;

  logic [10:0] in_exp;
  dtsd_fp_t rmul;
  dtsd_fp_t rdiv;
  logic ge_one;
  logic lt_tenth;
  logic below_one;
  logic [5:0] ishift;
  logic [3:0] ipart;
  logic [3:0] dig;
  logic [MANT_W-1:0] frac;

  logic signed [DEXP_W-1:0] xe;
  logic [DEXP_W-1:0] mag;
  logic [DEXP_W-1:0] rem;
  logic [3:0] eh;
  logic [3:0] et;
  logic [3:0] eo;

  dtsd_div10 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .m_i     (m_q),
    .rsp_o   (div_rsp)
  );

  dtsd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (emit_start),
    .job_i       (job),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .is_last_o   (is_last_o),
    .invalid_o   (invalid_o)
  );

  always_comb begin
    in_exp = value_bits_i[62:52];
    rmul = dtsd_round57({1'b0, m_q, 3'b000} + {3'b000, m_q, 1'b0}, 1'b0, e_q);
    rdiv = dtsd_round57({div_rsp.q, 1'b0}, div_rsp.sticky, e_q - 13'sd7);
    ge_one = (e_q >= ONE_EXP);
    lt_tenth = (e_q < TENTH_EXP) || ((e_q == TENTH_EXP) && (m_q < TENTH_MANT));
    below_one = (e_q < ONE_EXP);
    ishift = 6'(-e_q);
    ipart = 4'(m_q >> ishift);
    if (z_q || below_one) dig = 4'd0;
    else if (ipart > 4'd9) dig = 4'd9;
    else dig = ipart;
    frac = m_q - ({49'd0, dig} << ishift);
  end

  always_comb begin
    xe = e10_q - 10'sd1;
    mag = xe[DEXP_W-1] ? 10'(-xe) : 10'(xe);
    if (mag >= 10'd300) eh = 4'd3;
    else if (mag >= 10'd200) eh = 4'd2;
    else if (mag >= 10'd100) eh = 4'd1;
    else eh = 4'd0;
    rem = mag - 10'(10'(eh) * 10'd100);
    et = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 10'(k * 10)) et = 4'(k);
    end
    eo = 4'(rem - 10'(10'(et) * 10'd10));
    job.kind = kind_q;
    job.neg = neg_q;
    job.digits = dig_q;
    job.exp_neg = xe[DEXP_W-1];
    job.eh = eh;
    job.et = et;
    job.eo = eo;
  end

  always_comb begin
    state_d = state_q;
    m_d = m_q;
    e_d = e_q;
    e10_d = e10_q;
    neg_d = neg_q;
    mulph_d = mulph_q;
    z_d = z_q;
    indig_d = indig_q;
    kind_d = kind_q;
    dig_d = dig_q;
    dcnt_d = dcnt_q;
    div_start = 1'b0;
    emit_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_exp == 11'h7FF) begin
            kind_d = K_INVALID;
            state_d = S_EMIT;
          end else if (value_bits_i[62:0] == 63'd0) begin
            kind_d = K_ZERO;
            state_d = S_EMIT;
          end else begin
            kind_d = K_NUM;
            neg_d = value_bits_i[63];
            m_d = {in_exp != 11'd0, value_bits_i[51:0]};
            e_d = (in_exp == 11'd0) ? SUBNORM_EXP : ($signed({2'b00, in_exp}) - EXP_BIAS);
            e10_d = '0;
            mulph_d = 1'b0;
            z_d = 1'b0;
            indig_d = 1'b0;
            dcnt_d = '0;
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (m_q[MANT_W-1]) begin
          state_d = indig_q ? S_DMUL : S_SCALE;
        end else begin
          m_d = {m_q[MANT_W-2:0], 1'b0};
          e_d = e_q - 13'sd1;
        end
      end
      S_SCALE: begin
        if (!mulph_q && ge_one) begin
          div_start = 1'b1;
          state_d = S_DIV;
        end else if (lt_tenth) begin
          m_d = rmul.m;
          e_d = rmul.e;
          mulph_d = 1'b1;
          e10_d = e10_q - 10'sd1;
        end else begin
          indig_d = 1'b1;
          state_d = S_DMUL;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          m_d = rdiv.m;
          e_d = rdiv.e;
          e10_d = e10_q + 10'sd1;
          state_d = S_SCALE;
        end
      end
      S_DMUL: begin
        if (!z_q) begin
          m_d = rmul.m;
          e_d = rmul.e;
        end
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        dig_d[dcnt_q] = dig;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DIG_W'(FRACTION_DIGITS)) begin
          state_d = S_EMIT;
        end else if (!z_q && !below_one) begin
          if (frac == '0) begin
            z_d = 1'b1;
            state_d = S_DMUL;
          end else begin
            m_d = frac;
            state_d = S_NORM;
          end
        end else begin
          state_d = S_DMUL;
        end
      end
      S_EMIT: begin
        emit_start = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!emit_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    e_q <= e_d;
    e10_q <= e10_d;
    neg_q <= neg_d;
    mulph_q <= mulph_d;
    z_q <= z_d;
    indig_q <= indig_d;
    kind_q <= kind_d;
    dig_q <= dig_d;
    dcnt_q <= dcnt_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

>>> hdl/dtsd_checker.sv
// Port-level checker of the scientific-text block and its bind statement.
module dtsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] character_o,
  input logic       is_last_o,
  input logic       invalid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(character_o))
    else $error("Stalled output beat changed.");

  a_inv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> is_last_o && (character_o == 8'h00))
    else $error("Invalid beat is not a lone null character.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input not stalled after a beat was accepted.");

  a_text_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_o |-> (character_o != 8'h00))
    else $error("Text beat carries a null character.");

endmodule

bind double_to_scientific_decimal_text dtsd_checker u_dtsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .character_o (character_o),
  .is_last_o   (is_last_o),
  .invalid_o   (invalid_o)
);
